// File: rtl/cpt_pkg.sv
// Shared types and constants for the collider pair test.
package cpt_pkg;

  // Pair classes after the front has put the box first.
  localparam int KIND_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_BB,
    KIND_BC,
    KIND_CC
  } cpt_kind_t;

  // Number of edge or centre values carried in one descriptor word.
  localparam int EDGE_CNT = 8;

endpackage

// File: rtl/cpt_front.sv
// Front end: accepts a pair, classifies it and builds the descriptor word.
module cpt_front #(
  parameter int N  = 16,
  parameter int DW = 2 + 8 * (N + 1) + N
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_a_is_box,
  input  logic signed [N-1:0] in_a_x,
  input  logic signed [N-1:0] in_a_y,
  input  logic        [N-2:0] in_a_w,
  input  logic        [N-2:0] in_a_h,
  input  logic                in_b_is_box,
  input  logic signed [N-1:0] in_b_x,
  input  logic signed [N-1:0] in_b_y,
  input  logic        [N-2:0] in_b_w,
  input  logic        [N-2:0] in_b_h,
  output logic                push,
  output logic [DW-1:0]       push_word,
  input  logic                q_full
);
  import cpt_pkg::*;

  logic                valid_r, valid_nxt;
  logic [DW-1:0]       desc_r, desc_nxt;
  logic                accept;
  logic signed [N:0]   ax, ay, aw, ah, bx, by, bw, bh;
  logic signed [N:0]   a_r, a_b, b_r, b_b, a_cx, a_cy, b_cx, b_cy;
  logic [N-1:0]        rsum, rad_bc;
  cpt_kind_t           kind;
  logic signed [N:0]   e0, e1, e2, e3, e4, e5, e6, e7;
  logic [N-1:0]        rad;

  // The front holds one word; it stalls only while the queue is full.
  assign busy      = valid_r & q_full;
  assign accept    = start & ~busy;
  assign push      = valid_r & ~q_full;
  assign push_word = desc_r;

  // Sign-extend positions by one bit and zero-extend sizes by two bits, so sums cannot wrap.
  assign ax = {in_a_x[N-1], in_a_x};
  assign ay = {in_a_y[N-1], in_a_y};
  assign bx = {in_b_x[N-1], in_b_x};
  assign by = {in_b_y[N-1], in_b_y};
  assign aw = {2'b00, in_a_w};
  assign ah = {2'b00, in_a_h};
  assign bw = {2'b00, in_b_w};
  assign bh = {2'b00, in_b_h};

  // Far edges and circle centres.
  assign a_r  = ax + aw;
  assign a_b  = ay + ah;
  assign b_r  = bx + bw;
  assign b_b  = by + bh;
  assign a_cx = ax + aw;
  assign a_cy = ay + aw;
  assign b_cx = bx + bw;
  assign b_cy = by + bw;
  assign rsum   = {1'b0, in_a_w} + {1'b0, in_b_w};
  assign rad_bc = in_a_is_box ? {1'b0, in_b_w} : {1'b0, in_a_w};

  // Classify the pair and order it box first.
  always_comb begin
    e0 = a_cx; e1 = a_cy; e2 = b_cx; e3 = b_cy;
    e4 = '0;   e5 = '0;   e6 = '0;   e7 = '0;
    kind = KIND_CC;
    rad  = rsum;
    priority if (in_a_is_box && in_b_is_box) begin
      kind = KIND_BB;
      e0 = ax; e1 = a_r; e2 = ay; e3 = a_b;
      e4 = bx; e5 = b_r; e6 = by; e7 = b_b;
      rad = '0;
    end else if (in_a_is_box) begin
      kind = KIND_BC;
      e0 = ax; e1 = a_r; e2 = ay; e3 = a_b;
      e4 = b_cx; e5 = b_cy;
      rad = rad_bc;
    end else if (in_b_is_box) begin
      kind = KIND_BC;
      e0 = bx; e1 = b_r; e2 = by; e3 = b_b;
      e4 = a_cx; e5 = a_cy;
      rad = rad_bc;
    end else begin
      kind = KIND_CC;
    end
  end

  assign desc_nxt  = accept ? {kind, e7, e6, e5, e4, e3, e2, e1, e0, rad} : desc_r;
  assign valid_nxt = accept ? 1'b1 : (push ? 1'b0 : valid_r);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Descriptor word.
  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;
  end

endmodule

// File: rtl/cpt_fifo.sv
// Two-word queue between the front end and the back end.
module cpt_fifo #(
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_word,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output logic [DW-1:0] head
);

  logic [DW-1:0] mem_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue fill count out of range");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 2'd1))
    else $error("queue fill count did not advance");
`endif

endmodule

// File: rtl/cpt_back.sv
// Back end: overlap arithmetic, squared-distance test and push saturation.
module cpt_back #(
  parameter int N  = 16,
  parameter int DW = 2 + 8 * (N + 1) + N
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  logic [DW-1:0]       head,
  output logic                pop,
  output logic                out_valid,
  output logic                out_hit,
  output logic signed [N-1:0] out_push_x,
  output logic signed [N-1:0] out_push_y
);
  import cpt_pkg::*;

  localparam int EW = N + 1;

  // Unpacked head word.
  cpt_kind_t         h_kind;
  logic signed [N:0] e0, e1, e2, e3, e4, e5, e6, e7;
  logic [N-1:0]      h_rad;

  // Stage one: the two operands of each axis difference.
  logic signed [N:0] vx_nxt, wx_nxt, vy_nxt, wy_nxt;
  logic signed [N:0] l_v, r_v, t_v, b_v, mx_v, my_v;
  logic [3:0]        fl_nxt;
  logic              v1_r;
  cpt_kind_t         kind1_r;
  logic signed [N:0] vx1_r, wx1_r, vy1_r, wy1_r;
  logic [N-1:0]      rad1_r;
  logic [3:0]        fl1_r;

  // Stage two: the differences.
  logic                v2_r;
  cpt_kind_t           kind2_r;
  logic signed [N+1:0] dx2_r, dy2_r;
  logic [N-1:0]        rad2_r;
  logic [3:0]          fl2_r;

  // Stage three: squares.
  logic                v3_r;
  cpt_kind_t           kind3_r;
  logic signed [N+1:0] dx3_r, dy3_r;
  logic [2*N+3:0]      sqx3_r, sqy3_r;
  logic [2*N-1:0]      sqr3_r;
  logic [3:0]          fl3_r;
  logic signed [2*N+3:0] sqx_p, sqy_p;

  // Stage four: decision and output register.
  logic [2*N+4:0]      dist_sum;
  logic                hit_nxt;
  logic signed [N+1:0] px_w, py_w;
  logic                out_valid_r;
  logic                out_hit_r;
  logic signed [N-1:0] out_push_x_r, out_push_y_r;

  // The back end never stalls, so it drains the queue whenever it holds a word.
  assign pop = ~q_empty;

  assign h_kind = cpt_kind_t'(head[DW-1 -: KIND_W]);
  assign h_rad  = head[N-1:0];
  assign e0 = head[N + 0*EW +: EW];
  assign e1 = head[N + 1*EW +: EW];
  assign e2 = head[N + 2*EW +: EW];
  assign e3 = head[N + 3*EW +: EW];
  assign e4 = head[N + 4*EW +: EW];
  assign e5 = head[N + 5*EW +: EW];
  assign e6 = head[N + 6*EW +: EW];
  assign e7 = head[N + 7*EW +: EW];

  // Intersection rectangle for two boxes, closest box point for box and circle.
  assign l_v  = (e0 > e4) ? e0 : e4;
  assign r_v  = (e1 < e5) ? e1 : e5;
  assign t_v  = (e2 > e6) ? e2 : e6;
  assign b_v  = (e3 < e7) ? e3 : e7;
  assign mx_v = (e4 < e1) ? ((e4 > e0) ? e4 : e0) : ((e1 > e0) ? e1 : e0);
  assign my_v = (e5 < e3) ? ((e5 > e2) ? e5 : e2) : ((e3 > e2) ? e3 : e2);

  always_comb begin
    vx_nxt = e0; wx_nxt = e2; vy_nxt = e1; wy_nxt = e3;
    fl_nxt = '0;
    unique case (h_kind)
      KIND_BB: begin
        vx_nxt = r_v; wx_nxt = l_v; vy_nxt = b_v; wy_nxt = t_v;
        // Edge matches against the second box: left, right, top, bottom.
        fl_nxt = {b_v == e7, t_v == e6, r_v == e5, l_v == e4};
      end
      KIND_BC: begin
        vx_nxt = e4; wx_nxt = mx_v; vy_nxt = e5; wy_nxt = my_v;
      end
      KIND_CC: begin
        vx_nxt = e0; wx_nxt = e2; vy_nxt = e1; wy_nxt = e3;
      end
      default: begin
        vx_nxt = e0; wx_nxt = e2; vy_nxt = e1; wy_nxt = e3;
      end
    endcase
  end

  // Squares; all are non-negative, so the sign bit is dropped.
  assign sqx_p = dx2_r * dx2_r;
  assign sqy_p = dy2_r * dy2_r;

  // Squared-distance test, or the box overlap test on the differences carried from stage two.
  assign dist_sum = {1'b0, sqx3_r} + {1'b0, sqy3_r};

  always_comb begin
    hit_nxt = 1'b0;
    px_w    = '0;
    py_w    = '0;
    unique case (kind3_r)
      KIND_BB: begin
        hit_nxt = (dx3_r > 0) && (dy3_r > 0);
        // A right-edge match wins over a left-edge match, likewise bottom over top.
        priority if (fl3_r[1]) px_w = dx3_r;
        else if (fl3_r[0])     px_w = -dx3_r;
        else                   px_w = '0;
        priority if (fl3_r[3]) py_w = dy3_r;
        else if (fl3_r[2])     py_w = -dy3_r;
        else                   py_w = '0;
      end
      KIND_BC: begin
        hit_nxt = dist_sum < {5'b0, sqr3_r};
        px_w    = dx3_r;
        py_w    = dy3_r;
      end
      KIND_CC: begin
        hit_nxt = dist_sum < {5'b0, sqr3_r};
      end
      default: begin
        hit_nxt = 1'b0;
      end
    endcase
    if (!hit_nxt) begin
      px_w = '0;
      py_w = '0;
    end
  end

  function automatic logic signed [N-1:0] sat_push(input logic signed [N+1:0] v);
    logic fits;
    fits = (v[N+1:N-1] == 3'b000) || (v[N+1:N-1] == 3'b111);
    if (fits) begin
      sat_push = v[N-1:0];
    end else if (v[N+1]) begin
      sat_push = {1'b1, {(N-1){1'b0}}};
    end else begin
      sat_push = {1'b0, {(N-1){1'b1}}};
    end
  endfunction

  // Valid chain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= pop;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    kind1_r <= h_kind;
    vx1_r   <= vx_nxt;
    wx1_r   <= wx_nxt;
    vy1_r   <= vy_nxt;
    wy1_r   <= wy_nxt;
    rad1_r  <= h_rad;
    fl1_r   <= fl_nxt;

    kind2_r <= kind1_r;
    dx2_r   <= {vx1_r[N], vx1_r} - {wx1_r[N], wx1_r};
    dy2_r   <= {vy1_r[N], vy1_r} - {wy1_r[N], wy1_r};
    rad2_r  <= rad1_r;
    fl2_r   <= fl1_r;

    kind3_r <= kind2_r;
    dx3_r   <= dx2_r;
    dy3_r   <= dy2_r;
    sqx3_r  <= sqx_p;
    sqy3_r  <= sqy_p;
    sqr3_r  <= rad2_r * rad2_r;
    fl3_r   <= fl2_r;

    out_hit_r    <= hit_nxt & v3_r;
    out_push_x_r <= sat_push(px_w);
    out_push_y_r <= sat_push(py_w);
  end

  assign out_valid  = out_valid_r;
  assign out_hit    = out_hit_r;
  assign out_push_x = out_push_x_r;
  assign out_push_y = out_push_y_r;

`ifndef NO_ASSERTIONS
  a_miss_zero_push: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_push_x == '0 && out_push_y == '0))
    else $error("push vector not zero on a miss");
  a_circles_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && kind3_r == KIND_CC) |=> (out_push_x == '0 && out_push_y == '0))
    else $error("circle pair gave a push");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> ##4 out_valid) else $error("result word lost in the back end");
`endif

endmodule

// File: rtl/collider_pair_test_core.sv
// Top level of the collider pair test: front end, queue and back end.
//
//   Channel  Ports                       Handshake
//   input    start, busy, in_*           word taken when start high and busy low
//   result   out_valid, out_hit, out_push_*  one-cycle strobe, cannot be held off
//
// One pair is taken every cycle while busy is low; each result word passes
// through the front register, the queue, then four back-end stages, the
// multipliers of the squared-distance test setting the stage count.
// Reset is synchronous on rst_n low and clears all valid and queue state.
// The back end drains the queue every cycle, so busy rises only if the
// queue ever fills while the front register holds a word.
module collider_pair_test_core #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_a_is_box,
  input  logic signed [COORD_BITS-1:0] in_a_x,
  input  logic signed [COORD_BITS-1:0] in_a_y,
  input  logic        [COORD_BITS-2:0] in_a_w,
  input  logic        [COORD_BITS-2:0] in_a_h,
  input  logic                         in_b_is_box,
  input  logic signed [COORD_BITS-1:0] in_b_x,
  input  logic signed [COORD_BITS-1:0] in_b_y,
  input  logic        [COORD_BITS-2:0] in_b_w,
  input  logic        [COORD_BITS-2:0] in_b_h,
  output logic                         out_valid,
  output logic                         out_hit,
  output logic signed [COORD_BITS-1:0] out_push_x,
  output logic signed [COORD_BITS-1:0] out_push_y
);
  import cpt_pkg::*;

  localparam int DW = KIND_W + EDGE_CNT * (COORD_BITS + 1) + COORD_BITS;

  logic          push, q_full, pop, q_empty;
  logic [DW-1:0] push_word, head;

  cpt_front #(.N(COORD_BITS), .DW(DW)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_a_is_box (in_a_is_box),
    .in_a_x      (in_a_x),
    .in_a_y      (in_a_y),
    .in_a_w      (in_a_w),
    .in_a_h      (in_a_h),
    .in_b_is_box (in_b_is_box),
    .in_b_x      (in_b_x),
    .in_b_y      (in_b_y),
    .in_b_w      (in_b_w),
    .in_b_h      (in_b_h),
    .push        (push),
    .push_word   (push_word),
    .q_full      (q_full)
  );

  cpt_fifo #(.DW(DW)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  cpt_back #(.N(COORD_BITS), .DW(DW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_hit    (out_hit),
    .out_push_x (out_push_x),
    .out_push_y (out_push_y)
  );

endmodule
